[sv/qau_pkg.sv]
// Shared constants, types and op codes for the quaternion arithmetic unit.
`default_nettype none
package qau_pkg;

  // Fixed point format: signed Q(31-FRAC_BITS).FRAC_BITS in 32-bit words
  localparam int FRAC_BITS = 16;
  localparam int W         = 32;
  // exact sum of four squares of 32-bit values needs 65 unsigned bits
  localparam int SW        = 65;
  // root of a 65-bit value, with one padding bit to make an even word
  localparam int RW        = 33;
  // divider numerator |a| << FRAC_BITS
  localparam int NUMW      = W + FRAC_BITS;
  // squared magnitude shifted down, used as the inverse divisor
  localparam int QW        = SW - FRAC_BITS;
  localparam int DW        = (QW > RW) ? QW : RW;
  // front to back queue
  localparam int QD        = 4;
  localparam int QPW       = 2;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_SCALE = 4'd2,
    OP_MUL   = 4'd3,
    OP_NEG   = 4'd4,
    OP_CONJ  = 4'd5,
    OP_SQMAG = 4'd6,
    OP_MAG   = 4'd7,
    OP_NORM  = 4'd8,
    OP_INV   = 4'd9,
    OP_DOT   = 4'd10,
    OP_NOP   = 4'd11
  } op_t;

  // Classification of one item, made by the front part
  typedef struct packed {
    op_t  op;
    logic qlane;  // quaternion result from the product lanes
    logic ssum;   // scalar result from lane 0 sum
    logic sroot;  // scalar result from the square root
    logic dnorm;  // quaternion result from divider, by root
    logic dinv;   // quaternion result from divider, by squared magnitude
  } cls_t;

  typedef struct packed {
    cls_t                cls;
    logic [3:0][W-1:0]   a;
    logic [3:0][W-1:0]   b;
    logic [W-1:0]        c;
  } item_t;

endpackage
`default_nettype wire

[sv/quaternion_arithmetic_unit.sv]
// Data words are signed Q15.16 fixed point at the default FRAC_BITS of 16.
// Each beat passes the product stages, the 33-stage square root and the (32 + FRAC_BITS)-stage divider.
// Throughput: one beat per cycle; every stage advances whenever the result slot is free.
// A four-entry queue between classifier and pipeline absorbs short output stalls.
// Reset (rst_n low, synchronous) empties the queue and clears all valid bits.
// Top level of the quaternion arithmetic unit.
`default_nettype none
module quaternion_arithmetic_unit
  import qau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [3:0]    in_mode,
  input  wire logic [W-1:0]  in_a_s,
  input  wire logic [W-1:0]  in_a_x,
  input  wire logic [W-1:0]  in_a_y,
  input  wire logic [W-1:0]  in_a_z,
  input  wire logic [W-1:0]  in_b_s,
  input  wire logic [W-1:0]  in_b_x,
  input  wire logic [W-1:0]  in_b_y,
  input  wire logic [W-1:0]  in_b_z,
  input  wire logic [W-1:0]  in_scale_in,
  output logic               empty,
  input  wire logic          pop,
  output logic [W-1:0]       out_res_s,
  output logic [W-1:0]       out_res_x,
  output logic [W-1:0]       out_res_y,
  output logic [W-1:0]       out_res_z,
  output logic [W-1:0]       out_res_scalar,
  output logic               out_saturated
);

  logic  fq_push;
  logic  fq_full;
  logic  fq_empty;
  logic  fq_pop;
  item_t fq_wr_item;
  item_t fq_rd_item;

  qau_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_mode    (in_mode),
    .in_a_s     (in_a_s),
    .in_a_x     (in_a_x),
    .in_a_y     (in_a_y),
    .in_a_z     (in_a_z),
    .in_b_s     (in_b_s),
    .in_b_x     (in_b_x),
    .in_b_y     (in_b_y),
    .in_b_z     (in_b_z),
    .in_scale_in(in_scale_in),
    .fq_push    (fq_push),
    .fq_full    (fq_full),
    .fq_item    (fq_wr_item)
  );

  qau_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (fq_push),
    .wr_item(fq_wr_item),
    .full   (fq_full),
    .rd_en  (fq_pop),
    .rd_item(fq_rd_item),
    .empty  (fq_empty)
  );

  qau_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .fq_empty      (fq_empty),
    .fq_item       (fq_rd_item),
    .fq_pop        (fq_pop),
    .pop           (pop),
    .empty         (empty),
    .out_res_s     (out_res_s),
    .out_res_x     (out_res_x),
    .out_res_y     (out_res_y),
    .out_res_z     (out_res_z),
    .out_res_scalar(out_res_scalar),
    .out_saturated (out_saturated)
  );

endmodule
`default_nettype wire

[sv/qau_front.sv]
// Front part: takes input beats, classifies the operation, feeds the queue.
`default_nettype none
module qau_front
  import qau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  output logic               full,
  input  wire logic [3:0]    in_mode,
  input  wire logic [W-1:0]  in_a_s,
  input  wire logic [W-1:0]  in_a_x,
  input  wire logic [W-1:0]  in_a_y,
  input  wire logic [W-1:0]  in_a_z,
  input  wire logic [W-1:0]  in_b_s,
  input  wire logic [W-1:0]  in_b_x,
  input  wire logic [W-1:0]  in_b_y,
  input  wire logic [W-1:0]  in_b_z,
  input  wire logic [W-1:0]  in_scale_in,
  output logic               fq_push,
  input  wire logic          fq_full,
  output item_t              fq_item
);

  logic  hold_v_r;
  item_t hold_r;
  item_t cls_item;
  logic  accept;

  // Decode the mode into an op and its result routing
  always_comb begin
    cls_item       = '0;
    cls_item.a     = {in_a_z, in_a_y, in_a_x, in_a_s};
    cls_item.b     = {in_b_z, in_b_y, in_b_x, in_b_s};
    cls_item.c     = in_scale_in;
    unique case (in_mode)
      OP_ADD:   cls_item.cls.op = OP_ADD;
      OP_SUB:   cls_item.cls.op = OP_SUB;
      OP_SCALE: cls_item.cls.op = OP_SCALE;
      OP_MUL:   cls_item.cls.op = OP_MUL;
      OP_NEG:   cls_item.cls.op = OP_NEG;
      OP_CONJ:  cls_item.cls.op = OP_CONJ;
      OP_SQMAG: cls_item.cls.op = OP_SQMAG;
      OP_MAG:   cls_item.cls.op = OP_MAG;
      OP_NORM:  cls_item.cls.op = OP_NORM;
      OP_INV:   cls_item.cls.op = OP_INV;
      OP_DOT:   cls_item.cls.op = OP_DOT;
      default:  cls_item.cls.op = OP_NOP;
    endcase
    cls_item.cls.qlane = cls_item.cls.op inside {OP_ADD, OP_SUB, OP_SCALE, OP_MUL,
                                                 OP_NEG, OP_CONJ};
    cls_item.cls.ssum  = cls_item.cls.op inside {OP_SQMAG, OP_DOT};
    cls_item.cls.sroot = (cls_item.cls.op == OP_MAG);
    cls_item.cls.dnorm = (cls_item.cls.op == OP_NORM);
    cls_item.cls.dinv  = (cls_item.cls.op == OP_INV);
  end

  assign full    = hold_v_r && fq_full;
  assign accept  = push && !full;
  assign fq_push = hold_v_r;
  assign fq_item = hold_r;

  // Hold one classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (accept) begin
      hold_v_r <= 1'b1;
    end else if (!fq_full) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cls_item;
    end
  end

endmodule
`default_nettype wire

[sv/qau_fifo.sv]
// Short queue of classified items between the front and back parts.
`default_nettype none
module qau_fifo
  import qau_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  item_t      wr_item,
  output logic       full,
  input  wire logic  rd_en,
  output item_t      rd_item,
  output logic       empty
);

  item_t          mem_r [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   cnt_r;
  logic           do_wr;
  logic           do_rd;

  assign full    = (cnt_r == (QPW+1)'(QD));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Store a beat
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

[sv/qau_back.sv]
// Back part: product lanes, square root and divider pipelines, result register.
`default_nettype none
module qau_back
  import qau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fq_empty,
  input  item_t              fq_item,
  output logic               fq_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [W-1:0]       out_res_s,
  output logic [W-1:0]       out_res_x,
  output logic [W-1:0]       out_res_y,
  output logic [W-1:0]       out_res_z,
  output logic [W-1:0]       out_res_scalar,
  output logic               out_saturated
);

  localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

  typedef struct packed {
    logic [W-1:0] val;
    logic         flg;
  } sat_t;

  typedef struct packed {
    cls_t                 cls;
    logic [3:0][W-1:0]    qres;
    logic                 qflg;
    logic [W-1:0]         ssum;
    logic                 sflg;
    logic [DW-1:0]        qinv;
    logic [3:0][NUMW-1:0] num;
    logic [3:0]           sgn;
  } side_t;

  typedef struct packed {
    side_t           sd;
    logic [2*RW-1:0] v;
    logic [RW+1:0]   rem;
    logic [RW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic [DW-1:0]   rem;
    logic [NUMW-1:0] nq;
  } dl_t;

  typedef struct packed {
    side_t          sd;
    logic [RW-1:0]  root;
    logic [DW-1:0]  den;
    dl_t [3:0]      ln;
  } dv_t;

  // Clip a wide signed value to 32 bits
  function automatic sat_t sat_wide(input logic signed [65:0] t);
    sat_t r;
    r.flg = !((&t[65:W-1]) || !(|t[65:W-1]));
    if (r.flg) begin
      r.val = t[65] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r.val = t[W-1:0];
    end
    return r;
  endfunction

  // Apply sign to an unsigned quotient and clip
  function automatic sat_t div_sat(input logic [NUMW-1:0] q, input logic neg);
    sat_t r;
    if (!neg) begin
      r.flg = |q[NUMW-1:W-1];
      r.val = r.flg ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
    end else begin
      r.flg = (|q[NUMW-1:W]) || (q[W-1] && (|q[W-2:0]));
      r.val = r.flg ? {1'b1, {(W-1){1'b0}}} : (~q[W-1:0] + 1'b1);
    end
    return r;
  endfunction

  // One digit of the restoring square root
  function automatic sq_t sq_step(input sq_t s);
    sq_t              r;
    logic [RW+3:0]    rem2;
    logic [RW+3:0]    trial;
    r     = s;
    rem2  = {s.rem, s.v[2*RW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    if (rem2 >= trial) begin
      r.rem  = (RW+2)'(rem2 - trial);
      r.root = {s.root[RW-2:0], 1'b1};
    end else begin
      r.rem  = rem2[RW+1:0];
      r.root = {s.root[RW-2:0], 1'b0};
    end
    r.v = {s.v[2*RW-3:0], 2'b00};
    return r;
  endfunction

  // One quotient bit of the restoring divider
  function automatic dl_t dv_step(input dl_t l, input logic [DW-1:0] den);
    dl_t         r;
    logic [DW:0] r2;
    logic [DW:0] d;
    logic        ge;
    r2   = {l.rem, l.nq[NUMW-1]};
    d    = r2 - {1'b0, den};
    ge   = (r2 >= {1'b0, den});
    r.rem = ge ? d[DW-1:0] : r2[DW-1:0];
    r.nq  = {l.nq[NUMW-2:0], ge};
    return r;
  endfunction

  logic en;

  // ---------------- stage A: operand select and products
  logic signed [W-1:0]    x   [4][4];
  logic signed [W-1:0]    y   [4][4];
  logic                   ngs [4][4];
  logic signed [63:0]     p_r [4][4];
  logic                   ng_r[4][4];
  side_t                  a_sd_nxt;
  side_t                  a_sd_r;
  logic                   a_v_r;
  item_t                  it;

  assign it     = fq_item;
  assign en     = empty || pop;
  assign fq_pop = en && !fq_empty;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        x[j][k]   = '0;
        y[j][k]   = '0;
        ngs[j][k] = 1'b0;
      end
    end
    unique case (it.cls.op) inside
      OP_ADD, OP_SUB: begin
        for (int j = 0; j < 4; j++) begin
          x[j][0] = it.a[j]; y[j][0] = ONE;
          x[j][1] = it.b[j]; y[j][1] = ONE;
          ngs[j][1] = (it.cls.op == OP_SUB);
        end
      end
      OP_SCALE: begin
        for (int j = 0; j < 4; j++) begin
          x[j][0] = it.a[j]; y[j][0] = it.c;
        end
      end
      OP_MUL: begin
        x[0][0] = it.a[0]; y[0][0] = it.b[0];
        x[0][1] = it.a[1]; y[0][1] = it.b[1]; ngs[0][1] = 1'b1;
        x[0][2] = it.a[2]; y[0][2] = it.b[2]; ngs[0][2] = 1'b1;
        x[0][3] = it.a[3]; y[0][3] = it.b[3]; ngs[0][3] = 1'b1;
        x[1][0] = it.a[0]; y[1][0] = it.b[1];
        x[1][1] = it.b[0]; y[1][1] = it.a[1];
        x[1][2] = it.a[2]; y[1][2] = it.b[3];
        x[1][3] = it.a[3]; y[1][3] = it.b[2]; ngs[1][3] = 1'b1;
        x[2][0] = it.a[0]; y[2][0] = it.b[2];
        x[2][1] = it.b[0]; y[2][1] = it.a[2];
        x[2][2] = it.a[3]; y[2][2] = it.b[1];
        x[2][3] = it.a[1]; y[2][3] = it.b[3]; ngs[2][3] = 1'b1;
        x[3][0] = it.a[0]; y[3][0] = it.b[3];
        x[3][1] = it.b[0]; y[3][1] = it.a[3];
        x[3][2] = it.a[1]; y[3][2] = it.b[2];
        x[3][3] = it.a[2]; y[3][3] = it.b[1]; ngs[3][3] = 1'b1;
      end
      OP_NEG, OP_CONJ: begin
        for (int j = 0; j < 4; j++) begin
          x[j][0] = it.a[j]; y[j][0] = ONE;
          ngs[j][0] = (it.cls.op == OP_NEG) || (j != 0);
        end
      end
      OP_SQMAG, OP_MAG, OP_NORM, OP_INV: begin
        for (int k = 0; k < 4; k++) begin
          x[0][k] = it.a[k]; y[0][k] = it.a[k];
        end
      end
      OP_DOT: begin
        for (int k = 0; k < 4; k++) begin
          x[0][k] = it.a[k]; y[0][k] = it.b[k];
        end
      end
      default: begin
      end
    endcase
  end

  // Numerators and signs for the divider
  always_comb begin
    a_sd_nxt     = '0;
    a_sd_nxt.cls = it.cls;
    for (int k = 0; k < 4; k++) begin
      a_sd_nxt.num[k] = {(it.a[k][W-1] ? (~it.a[k] + 1'b1) : it.a[k]),
                         {FRAC_BITS{1'b0}}};
      a_sd_nxt.sgn[k] = it.cls.dinv ? (it.a[k][W-1] ^ (k != 0)) : it.a[k][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sd_r <= a_sd_nxt;
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          p_r[j][k]  <= x[j][k] * y[j][k];
          ng_r[j][k] <= ngs[j][k];
        end
      end
    end
  end

  // ---------------- stage B: signed pair sums
  logic signed [64:0] pr_r [4][2];
  side_t              b_sd_r;
  logic               b_v_r;
  logic signed [64:0] ext  [4][4];

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      for (int k = 0; k < 4; k++) begin
        ext[j][k] = ng_r[j][k] ? -$signed({p_r[j][k][63], p_r[j][k]})
                               :  $signed({p_r[j][k][63], p_r[j][k]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sd_r <= a_sd_r;
      for (int j = 0; j < 4; j++) begin
        pr_r[j][0] <= ext[j][0] + ext[j][1];
        pr_r[j][1] <= ext[j][2] + ext[j][3];
      end
    end
  end

  // ---------------- stage C: lane sums
  logic signed [65:0] ln_r [4];
  side_t              c_sd_r;
  logic               c_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c_sd_r <= b_sd_r;
      for (int j = 0; j < 4; j++) begin
        ln_r[j] <= $signed({pr_r[j][0][64], pr_r[j][0]}) +
                   $signed({pr_r[j][1][64], pr_r[j][1]});
      end
    end
  end

  // ---------------- stage D: clip lane results, seed the square root
  sq_t               sq_init;
  sat_t              lsat [4];
  logic [SW-1:0]     ssq;

  always_comb begin
    sq_init    = '0;
    sq_init.sd = c_sd_r;
    sq_init.sd.qflg = 1'b0;
    for (int j = 0; j < 4; j++) begin
      lsat[j] = sat_wide(ln_r[j] >>> FRAC_BITS);
      sq_init.sd.qres[j] = lsat[j].val;
      sq_init.sd.qflg    = sq_init.sd.qflg | lsat[j].flg;
    end
    sq_init.sd.ssum = lsat[0].val;
    sq_init.sd.sflg = lsat[0].flg;
    ssq             = ln_r[0][SW-1:0];
    sq_init.sd.qinv = DW'(ssq >> FRAC_BITS);
    sq_init.v       = {{(2*RW-SW){1'b0}}, ssq};
  end

  // ---------------- square root pipeline, one root bit a stage
  sq_t         sq_r [RW+1];
  logic [RW:0] sq_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq_init;
    end
  end

  for (genvar g = 0; g < RW; g++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[g+1] <= sq_step(sq_r[g]);
      end
    end
  end

  // ---------------- divider pipeline, one quotient bit a stage, four lanes
  dv_t           dv_init;
  dv_t           dv_r [NUMW+1];
  logic [NUMW:0] dv_v_r;

  always_comb begin
    dv_init      = '0;
    dv_init.sd   = sq_r[RW].sd;
    dv_init.root = sq_r[RW].root;
    dv_init.den  = sq_r[RW].sd.cls.dnorm ? DW'(sq_r[RW].root) : sq_r[RW].sd.qinv;
    for (int k = 0; k < 4; k++) begin
      dv_init.ln[k].rem = '0;
      dv_init.ln[k].nq  = sq_r[RW].sd.num[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv_init;
    end
  end

  for (genvar g = 0; g < NUMW; g++) begin : g_dv
    dv_t dv_nxt;

    // Carry the side data and step every lane
    always_comb begin
      dv_nxt = dv_r[g];
      for (int k = 0; k < 4; k++) begin
        dv_nxt.ln[k] = dv_step(dv_r[g].ln[k], dv_r[g].den);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[g+1] <= dv_nxt;
      end
    end
  end

  // ---------------- result select
  dv_t                 dl;
  sat_t                qs [4];
  logic [3:0][W-1:0]   res_nxt;
  logic [W-1:0]        scl_nxt;
  logic                flg_nxt;
  logic [3:0][W-1:0]   res_r;
  logic [W-1:0]        scl_r;
  logic                flg_r;
  cls_t                out_cls_r;
  logic                out_v_r;

  assign dl = dv_r[NUMW];

  always_comb begin
    res_nxt = '0;
    scl_nxt = '0;
    flg_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      qs[k] = div_sat(dl.ln[k].nq, dl.sd.sgn[k]);
    end
    if (dl.sd.cls.qlane) begin
      res_nxt = dl.sd.qres;
      flg_nxt = dl.sd.qflg;
    end
    if ((dl.sd.cls.dnorm || dl.sd.cls.dinv) && (dl.den != '0)) begin
      for (int k = 0; k < 4; k++) begin
        res_nxt[k] = qs[k].val;
        flg_nxt    = flg_nxt | qs[k].flg;
      end
    end
    if (dl.sd.cls.ssum) begin
      scl_nxt = dl.sd.ssum;
      flg_nxt = dl.sd.sflg;
    end
    if (dl.sd.cls.sroot) begin
      flg_nxt = |dl.root[RW-1:W-1];
      scl_nxt = flg_nxt ? {1'b0, {(W-1){1'b1}}} : dl.root[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r     <= res_nxt;
      scl_r     <= scl_nxt;
      flg_r     <= flg_nxt;
      out_cls_r <= dl.sd.cls;
    end
  end

  // Advance valid bits through every stage while the result slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      a_v_r   <= !fq_empty;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      sq_v_r  <= {sq_v_r[RW-1:0], c_v_r};
      dv_v_r  <= {dv_v_r[NUMW-1:0], sq_v_r[RW]};
      out_v_r <= dv_v_r[NUMW];
    end
  end

  assign empty          = !out_v_r;
  assign out_res_s      = res_r[0];
  assign out_res_x      = res_r[1];
  assign out_res_y      = res_r[2];
  assign out_res_z      = res_r[3];
  assign out_res_scalar = scl_r;
  assign out_saturated  = flg_r;

  // Unknown ops give an all-zero beat
  a_nop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_cls_r.op == OP_NOP) |->
      (res_r == '0) && (scl_r == '0) && !flg_r)
    else $error("unknown op gave a nonzero result");

  // Normalize never clips
  a_norm_noclip: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_cls_r.op == OP_NORM) |-> !flg_r)
    else $error("normalize clipped");

  // Scalar ops leave the quaternion fields zero
  a_scalar_qzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && ((out_cls_r.op == OP_SQMAG) || (out_cls_r.op == OP_MAG) ||
                (out_cls_r.op == OP_DOT)) |-> (res_r == '0))
    else $error("scalar op drove the quaternion fields");

  // A beat taken from the queue enters the product stage
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |=> a_v_r)
    else $error("popped beat lost at the product stage");

endmodule
`default_nettype wire
